FILE: design/bos_pkg.sv
package bos_pkg;

  // Largest image the coverage map is sized for.
  localparam int MAX_COLS = 640;
  localparam int MAX_ROWS = 480;

  localparam int MAP_DEPTH = MAX_COLS * MAX_ROWS;
  localparam int ADDR_W    = $clog2(MAP_DEPTH);

  // Field widths of the box description and the image registers.
  localparam int COL_W  = 10;
  localparam int ROW_W  = 9;
  localparam int AREA_W = COL_W + ROW_W;

  // Each map entry holds the frame tag of the last frame that covered it.
  localparam int                 EPOCH_W     = 8;
  localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
  localparam logic [EPOCH_W-1:0] EPOCH_LAST  = {EPOCH_W{1'b1}};

  // Configuration port.
  localparam int                   CFG_IDX_W      = 2;
  localparam int                   CFG_DATA_W     = 10;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_COLS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_ROWS = CFG_IDX_W'(1);
  localparam logic [COL_W-1:0]     COLS_RESET     = COL_W'(640);
  localparam logic [ROW_W-1:0]     ROWS_RESET     = ROW_W'(480);

  // Stream payload widths.
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 8;

endpackage

FILE: design/bos_ram.sv
module bos_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: design/box_overlap_suppressor_top.sv
// Greedy box overlap suppression. Boxes stream in one beat at a time and each
// yields one keep beat. The block keeps a coverage map of the image in one
// memory; every entry holds a small frame tag, and a pixel counts as covered
// when its tag equals the tag of the current frame, so a box flagged as the
// start of a frame clears the map just by advancing the tag. A box passes
// through setup, a scan of its pixels inside the image, drain and done; the
// memory port reads one pixel per cycle and writes it back marked in the
// next cycle. Boxes with no pixel inside the image skip the scan and the
// drain. After reset, and on every 255th frame start when the tag wraps,
// the block sweeps the whole map to zero, one entry per cycle, and takes no box
// meanwhile; configuration writes are accepted at any time but should only be
// issued while no box is in flight. A finished keep beat waits in an output
// register, so the next box can be taken while it is still pending.
module box_overlap_suppressor_top (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // Box input. in_tdata, from bit 0: box_left[9:0], box_top[8:0],
  // box_width[9:0], box_height[8:0], two zero bits.
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [bos_pkg::IN_TDATA_W-1:0]       in_tdata,
  // in_tuser, from bit 0: frame_start.
  input  logic                                 in_tuser,
  // Result. out_tdata, from bit 0: keep, seven zero bits.
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [bos_pkg::OUT_TDATA_W-1:0]      out_tdata,
  // Configuration writes: index 0 is image_cols, index 1 is image_rows.
  input  logic                                 cfg_we,
  input  logic [bos_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [bos_pkg::CFG_DATA_W-1:0]       cfg_wdata
);

  import bos_pkg::*;

  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_SETUP = 6'b000100,
    ST_SCAN  = 6'b001000,
    ST_DRAIN = 6'b010000,
    ST_DONE  = 6'b100000
  } state_t;

  state_t               state_r, state_nxt;
  logic [ADDR_W-1:0]    clr_addr_r, clr_addr_nxt;
  logic                 pend_r, pend_nxt;
  logic [EPOCH_W-1:0]   epoch_r, epoch_nxt;

  logic [COL_W-1:0]     image_cols_r;
  logic [ROW_W-1:0]     image_rows_r;

  // Box being handled, with the image size clamped to the map.
  logic [COL_W-1:0]     left_r, left_nxt;
  logic [ROW_W-1:0]     top_r, top_nxt;
  logic [COL_W-1:0]     width_r, width_nxt;
  logic [ROW_W-1:0]     height_r, height_nxt;
  logic [COL_W-1:0]     cols_r, cols_nxt;
  logic [ROW_W-1:0]     rows_r, rows_nxt;

  // Scan state.
  logic [COL_W-1:0]     xend_r, xend_nxt;
  logic [ROW_W-1:0]     yend_r, yend_nxt;
  logic [COL_W-1:0]     x_r, x_nxt;
  logic [ROW_W-1:0]     y_r, y_nxt;
  logic [ADDR_W-1:0]    row_base_r, row_base_nxt;
  logic [AREA_W-1:0]    area_r, area_nxt;
  logic [AREA_W-1:0]    covered_r, covered_nxt;

  // Write-back stage: a read issued last cycle whose data is arriving now.
  logic                 wb_valid_r, wb_valid_nxt;
  logic [ADDR_W-1:0]    wb_addr_r, wb_addr_nxt;

  logic                 out_tvalid_r, out_tvalid_nxt;
  logic                 out_keep_r, out_keep_nxt;

  // Memory port signals.
  logic                 ram_wr_en;
  logic [ADDR_W-1:0]    ram_wr_addr;
  logic [EPOCH_W-1:0]   ram_wr_data;
  logic                 ram_rd_en;
  logic [ADDR_W-1:0]    ram_rd_addr;
  logic [EPOCH_W-1:0]   ram_rd_data;

  // Combinational helpers.
  logic                 in_accept;
  logic [COL_W:0]       xsum;
  logic [ROW_W:0]       ysum;
  logic [COL_W-1:0]     xend_calc;
  logic [ROW_W-1:0]     yend_calc;
  logic [AREA_W-1:0]    row_prod;
  logic [COL_W-1:0]     cols_sat;
  logic [ROW_W-1:0]     rows_sat;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_accept  = in_tvalid && in_tready;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {{(OUT_TDATA_W-1){1'b0}}, out_keep_r};

  // Register values above the map size are clamped so the map is never
  // indexed past its end.
  assign cols_sat = (32'(image_cols_r) > MAX_COLS) ? COL_W'(MAX_COLS) : image_cols_r;
  assign rows_sat = (32'(image_rows_r) > MAX_ROWS) ? ROW_W'(MAX_ROWS) : image_rows_r;

  // The scan stops at the image edge; pixels beyond it are neither read nor
  // marked, yet still count in the area as uncovered.
  assign xsum      = {1'b0, left_r} + {1'b0, width_r};
  assign ysum      = {1'b0, top_r} + {1'b0, height_r};
  assign xend_calc = (xsum > {1'b0, cols_r}) ? cols_r : xsum[COL_W-1:0];
  assign yend_calc = (ysum > {1'b0, rows_r}) ? rows_r : ysum[ROW_W-1:0];
  assign row_prod  = AREA_W'(top_r) * AREA_W'(cols_r);

  // The sweep and the write-back never run at the same time.
  assign ram_wr_en   = (state_r == ST_CLEAR) || wb_valid_r;
  assign ram_wr_addr = (state_r == ST_CLEAR) ? clr_addr_r : wb_addr_r;
  assign ram_wr_data = (state_r == ST_CLEAR) ? '0 : epoch_r;
  assign ram_rd_en   = (state_r == ST_SCAN);
  assign ram_rd_addr = row_base_r + ADDR_W'(x_r);

  always_comb begin
    state_nxt      = state_r;
    clr_addr_nxt   = clr_addr_r;
    pend_nxt       = pend_r;
    epoch_nxt      = epoch_r;
    left_nxt       = left_r;
    top_nxt        = top_r;
    width_nxt      = width_r;
    height_nxt     = height_r;
    cols_nxt       = cols_r;
    rows_nxt       = rows_r;
    xend_nxt       = xend_r;
    yend_nxt       = yend_r;
    x_nxt          = x_r;
    y_nxt          = y_r;
    row_base_nxt   = row_base_r;
    area_nxt       = area_r;
    covered_nxt    = covered_r;
    wb_valid_nxt   = 1'b0;
    wb_addr_nxt    = wb_addr_r;
    out_tvalid_nxt = out_tvalid_r;
    out_keep_nxt   = out_keep_r;

    // A pixel whose tag matches the current frame was covered by an earlier
    // box; the write-back marks it with the current tag either way.
    if (wb_valid_r && (ram_rd_data == epoch_r)) begin
      covered_nxt = covered_r + AREA_W'(1);
    end

    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end

    case (state_r)
      ST_CLEAR: begin
        if (clr_addr_r == ADDR_W'(MAP_DEPTH - 1)) begin
          clr_addr_nxt = '0;
          pend_nxt     = 1'b0;
          state_nxt    = pend_r ? ST_SETUP : ST_IDLE;
        end else begin
          clr_addr_nxt = clr_addr_r + ADDR_W'(1);
        end
      end

      ST_IDLE: begin
        if (in_accept) begin
          left_nxt   = in_tdata[9:0];
          top_nxt    = in_tdata[18:10];
          width_nxt  = in_tdata[28:19];
          height_nxt = in_tdata[37:29];
          cols_nxt   = cols_sat;
          rows_nxt   = rows_sat;
          state_nxt  = ST_SETUP;
          if (in_tuser) begin
            if (epoch_r == EPOCH_LAST) begin
              // Tags are used up: wipe the map, then handle this box.
              epoch_nxt = EPOCH_FIRST;
              pend_nxt  = 1'b1;
              state_nxt = ST_CLEAR;
            end else begin
              epoch_nxt = epoch_r + EPOCH_W'(1);
            end
          end
        end
      end

      ST_SETUP: begin
        xend_nxt     = xend_calc;
        yend_nxt     = yend_calc;
        x_nxt        = left_r;
        y_nxt        = top_r;
        row_base_nxt = ADDR_W'(row_prod);
        area_nxt     = AREA_W'(width_r) * AREA_W'(height_r);
        covered_nxt  = '0;
        if ((width_r != '0) && (height_r != '0) &&
            (left_r < xend_calc) && (top_r < yend_calc)) begin
          state_nxt = ST_SCAN;
        end else begin
          state_nxt = ST_DONE;
        end
      end

      ST_SCAN: begin
        wb_valid_nxt = 1'b1;
        wb_addr_nxt  = ram_rd_addr;
        if ((x_r + COL_W'(1)) == xend_r) begin
          x_nxt        = left_r;
          y_nxt        = y_r + ROW_W'(1);
          row_base_nxt = row_base_r + ADDR_W'(cols_r);
          if ((y_r + ROW_W'(1)) == yend_r) begin
            state_nxt = ST_DRAIN;
          end
        end else begin
          x_nxt = x_r + COL_W'(1);
        end
      end

      ST_DRAIN: begin
        // The last pixel is written back in this cycle.
        state_nxt = ST_DONE;
      end

      ST_DONE: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_keep_nxt   = (area_r != '0) &&
                           ({covered_r, 1'b0} <= {1'b0, area_r});
          state_nxt      = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      clr_addr_r   <= '0;
      pend_r       <= 1'b0;
      epoch_r      <= EPOCH_FIRST;
      wb_valid_r   <= 1'b0;
      out_tvalid_r <= 1'b0;
      image_cols_r <= COLS_RESET;
      image_rows_r <= ROWS_RESET;
    end else begin
      state_r      <= state_nxt;
      clr_addr_r   <= clr_addr_nxt;
      pend_r       <= pend_nxt;
      epoch_r      <= epoch_nxt;
      wb_valid_r   <= wb_valid_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_IMAGE_COLS: image_cols_r <= cfg_wdata[COL_W-1:0];
          REG_IMAGE_ROWS: image_rows_r <= cfg_wdata[ROW_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    left_r     <= left_nxt;
    top_r      <= top_nxt;
    width_r    <= width_nxt;
    height_r   <= height_nxt;
    cols_r     <= cols_nxt;
    rows_r     <= rows_nxt;
    xend_r     <= xend_nxt;
    yend_r     <= yend_nxt;
    x_r        <= x_nxt;
    y_r        <= y_nxt;
    row_base_r <= row_base_nxt;
    area_r     <= area_nxt;
    covered_r  <= covered_nxt;
    wb_addr_r  <= wb_addr_nxt;
    out_keep_r <= out_keep_nxt;
  end

  bos_ram #(
    .WIDTH (EPOCH_W),
    .DEPTH (MAP_DEPTH)
  ) u_map (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

endmodule
